// File: rtl/qdc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qdc_pkg: shared types and constants of the 3x3 depthwise convolution
// Sizes, register indexes, the configuration bundle and the window beat
// that passes from the front end to the arithmetic back end.
// ----------------------------------------------------------------------------
package qdc_pkg;

   // Line store geometry.
   localparam int MAX_PADDED_WIDTH = 256;
   localparam int COL_W            = $clog2(MAX_PADDED_WIDTH);
   localparam int CNT_W            = COL_W + 1;
   localparam int PW_W             = 9;

   // Requantization.
   localparam int SCALE_FRAC = 24;
   localparam int ACC_W      = 34;
   localparam int ROW_W      = 19;
   localparam int PROD_W     = 17;
   localparam int MAG_W      = 32;
   localparam int HALF_W     = 48;
   localparam int FULL_W     = 64;
   localparam int QRAW_W     = FULL_W - SCALE_FRAC;
   localparam int Q_W        = 11;
   localparam int Q_MAX      = 1024;

   // Window queue between front and back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);

   // Configuration port.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;

   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHTS_LOW  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT_LAST  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BIAS         = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_MULT   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_IN_ZERO      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_ZERO     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_PADDED_WIDTH = 3'd6;

   localparam logic [31:0] SCALE_RESET = 32'h0100_0000;

   typedef struct packed {
      logic [63:0]        weights_low;
      logic signed [7:0]  weight_last;
      logic signed [31:0] bias;
      logic [31:0]        scale_mult;
      logic [7:0]         in_zero;
      logic [7:0]         out_zero;
      logic [PW_W-1:0]    padded_width;
   } cfg_type;

   // One full 3x3 window, tap t = 3*row + column.
   typedef struct packed {
      logic [8:0][7:0] sample;
      logic            row_last;
   } win_type;

endpackage

// File: rtl/qdc_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qdc_req_if: pixel input channel
// Valid/ready channel that carries one pixel beat of the padded frame.
// ----------------------------------------------------------------------------
interface qdc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] pixel;
   logic       is_pad;
   logic       frame_start;

   modport source (output valid, output pixel, output is_pad, output frame_start,
                   input ready);
   modport sink   (input valid, input pixel, input is_pad, input frame_start,
                   output ready);
endinterface

// File: rtl/qdc_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qdc_rsp_if: result output channel
// Valid/ready channel that carries one requantized result beat.
// ----------------------------------------------------------------------------
interface qdc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_value;
   logic       row_last;

   modport source (output valid, output out_value, output row_last, input ready);
   modport sink   (input valid, input out_value, input row_last, output ready);
endinterface

// File: rtl/quantized_depthwise_conv3x3.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quantized_depthwise_conv3x3: 8-bit 3x3 depthwise convolution, requantized
// One channel plane of a padded frame streams in on req in raster order,
// one pixel per beat; results leave on rsp, one per window position.
// ----------------------------------------------------------------------------
// Usage:
//  - req carries pixel, is_pad and frame_start; a pad beat takes in_zero as
//    its value, and frame_start restarts the row and column count.
//  - rsp carries out_value and row_last for every beat whose window lies
//    fully inside the frame (third row on, third column on).
//  - csr_we, csr_index and csr_wdata write the configuration registers;
//    write them only while the block is idle.
//  - Throughput is one pixel per cycle while the queue has room; the line store does one read and one
//    write per beat on a memory with one read port and one write port, with
//    the write in the cycle after the read and forwarded to a following beat
//    on the same column.
//  - A result passes the second intake stage, the window queue and the
//    arithmetic back end on its way out.
//  - A four-entry window queue sits between intake and arithmetic; when rsp
//    stalls the arithmetic pipeline holds and req drops ready once the queue
//    can take no more windows.
//  - Reset clears counters, window, line store valid bits (the line store
//    reads as zero until written) and loads the register reset values; it
//    is synchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module quantized_depthwise_conv3x3 (
   input  logic                             clock,
   input  logic                             reset,
   qdc_req_if.sink                          req,
   qdc_rsp_if.source                        rsp,
   input  logic                             csr_we,
   input  logic [qdc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [qdc_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   qdc_pkg::cfg_type            cfg_ff;
   logic                        q_push, q_pop, q_not_empty;
   qdc_pkg::win_type            q_push_data, q_pop_data;
   logic [qdc_pkg::QLVL_W-1:0]  q_level;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.weights_low  <= '0;
         cfg_ff.weight_last  <= '0;
         cfg_ff.bias         <= '0;
         cfg_ff.scale_mult   <= qdc_pkg::SCALE_RESET;
         cfg_ff.in_zero      <= '0;
         cfg_ff.out_zero     <= '0;
         cfg_ff.padded_width <= qdc_pkg::PW_W'(qdc_pkg::MAX_PADDED_WIDTH);
      end else if (csr_we) begin
         unique case (csr_index)
            qdc_pkg::CSR_WEIGHTS_LOW:  cfg_ff.weights_low  <= csr_wdata;
            qdc_pkg::CSR_WEIGHT_LAST:  cfg_ff.weight_last  <= $signed(csr_wdata[7:0]);
            qdc_pkg::CSR_BIAS:         cfg_ff.bias         <= $signed(csr_wdata[31:0]);
            qdc_pkg::CSR_SCALE_MULT:   cfg_ff.scale_mult   <= csr_wdata[31:0];
            qdc_pkg::CSR_IN_ZERO:      cfg_ff.in_zero      <= csr_wdata[7:0];
            qdc_pkg::CSR_OUT_ZERO:     cfg_ff.out_zero     <= csr_wdata[7:0];
            qdc_pkg::CSR_PADDED_WIDTH: cfg_ff.padded_width <= csr_wdata[qdc_pkg::PW_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Intake and window builder.
   qdc_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req),
      .cfg     (cfg_ff),
      .q_level (q_level),
      .q_push  (q_push),
      .q_data  (q_push_data)
   );

   // Window queue.
   qdc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_data  (q_pop_data),
      .level     (q_level)
   );

   // Arithmetic back end.
   qdc_back u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .q_valid (q_not_empty),
      .q_data  (q_pop_data),
      .q_pop   (q_pop),
      .rsp     (rsp)
   );

   // The queue never holds more windows than it has entries.
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      q_level <= qdc_pkg::QLVL_W'(qdc_pkg::QUEUE_DEPTH))
      else $error("window queue level beyond its depth");

   // A window is never pushed into a full queue.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> (q_level < qdc_pkg::QLVL_W'(qdc_pkg::QUEUE_DEPTH)))
      else $error("window pushed into a full queue");

   // Nothing is popped from an empty queue.
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_not_empty)
      else $error("window popped from an empty queue");

   // No result beat is offered right after reset.
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp.valid)
      else $error("result valid right after reset");

endmodule

// File: rtl/qdc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qdc_front: pixel intake, line store and window builder
// Tracks row and column, substitutes the pad value, reads and updates the
// two-row line store and assembles the 3x3 window for each result position.
// ----------------------------------------------------------------------------
module qdc_front (
   input  logic                      clock,
   input  logic                      reset,
   qdc_req_if.sink                   req,
   input  qdc_pkg::cfg_type          cfg,
   input  logic [qdc_pkg::QLVL_W-1:0] q_level,
   output logic                      q_push,
   output qdc_pkg::win_type          q_data
);

   localparam int COL_W = qdc_pkg::COL_W;
   localparam int CNT_W = qdc_pkg::CNT_W;
   localparam int DEPTH = qdc_pkg::MAX_PADDED_WIDTH;

   // Position counters.
   logic [COL_W-1:0] col_ff, col_in;
   logic [1:0]       row_ff, row_in;

   // Second stage: line store read data is available here.
   logic             b_valid_ff;
   logic [COL_W-1:0] b_addr_ff;
   logic [7:0]       b_v_ff;
   logic             b_last_ff;
   logic             b_emit_ff;
   logic             b_fwd_ff;
   logic [15:0]      b_fwd_data_ff;
   logic             b_colvalid_ff;
   logic [15:0]      rd_data_ff;

   // Line store: one word per column, upper byte two rows up, lower byte one up.
   logic [15:0]      line_mem [DEPTH];
   logic [DEPTH-1:0] colvalid_ff;

   // Window columns two and one to the left.
   logic [2:0][7:0]  wc0_ff, wc1_ff;

   logic             accept;
   logic [CNT_W-1:0] width, width_m1;
   logic [COL_W-1:0] cur_col, c;
   logic [1:0]       cur_row;
   logic             last, emit;
   logic [7:0]       v;
   logic [15:0]      old_word, wr_word;
   logic [2:0][7:0]  col;
   logic [qdc_pkg::QLVL_W:0] in_flight;

   // Effective row width, clamped to the supported range.
   always_comb begin
      if (cfg.padded_width < qdc_pkg::PW_W'(3)) begin
         width = CNT_W'(3);
      end else if (int'(cfg.padded_width) > DEPTH) begin
         width = CNT_W'(DEPTH);
      end else begin
         width = CNT_W'(cfg.padded_width);
      end
      width_m1 = width - CNT_W'(1);
   end

   // Keep room in the queue for every window that could still be pushed.
   assign in_flight = {1'b0, q_level} + {{qdc_pkg::QLVL_W{1'b0}}, b_valid_ff};
   assign req.ready = in_flight < (qdc_pkg::QLVL_W + 1)'(qdc_pkg::QUEUE_DEPTH);
   assign accept    = req.valid && req.ready;

   // Classify the incoming beat: column, end of row, result or not.
   always_comb begin
      cur_col = req.frame_start ? '0 : col_ff;
      cur_row = req.frame_start ? 2'd0 : row_ff;
      if ({1'b0, cur_col} >= width) begin
         c = width_m1[COL_W-1:0];
      end else begin
         c = cur_col;
      end
      last = ({1'b0, c} == width_m1);
      emit = (cur_row >= 2'd2) && (c >= COL_W'(2));
      v    = req.is_pad ? cfg.in_zero : req.pixel;
      col_in = last ? '0 : c + COL_W'(1);
      row_in = (last && cur_row != 2'd2) ? cur_row + 2'd1 : cur_row;
   end

   // Column of three samples; a write to the same column in the read cycle is
   // forwarded, and a column never written reads as zero.
   always_comb begin
      if (b_fwd_ff) begin
         old_word = b_fwd_data_ff;
      end else if (b_colvalid_ff) begin
         old_word = rd_data_ff;
      end else begin
         old_word = '0;
      end
      col[0]  = old_word[15:8];
      col[1]  = old_word[7:0];
      col[2]  = b_v_ff;
      wr_word = {old_word[7:0], b_v_ff};
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= 2'd0;
         b_valid_ff  <= 1'b0;
         colvalid_ff <= '0;
         wc0_ff      <= '0;
         wc1_ff      <= '0;
      end else begin
         b_valid_ff <= accept;
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
         if (b_valid_ff) begin
            colvalid_ff[b_addr_ff] <= 1'b1;
            wc0_ff <= wc1_ff;
            wc1_ff <= col;
         end
      end
   end

   // Second stage payload.
   always_ff @(posedge clock) begin
      if (accept) begin
         b_addr_ff     <= c;
         b_v_ff        <= v;
         b_last_ff     <= last;
         b_emit_ff     <= emit;
         b_fwd_ff      <= b_valid_ff && (b_addr_ff == c);
         b_fwd_data_ff <= wr_word;
         b_colvalid_ff <= colvalid_ff[c];
      end
   end

   // Line store memory: read on accept, write back in the following cycle.
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_data_ff <= line_mem[c];
      end
      if (b_valid_ff) begin
         line_mem[b_addr_ff] <= wr_word;
      end
   end

   // Window beat to the queue.
   always_comb begin
      q_push = b_valid_ff && b_emit_ff;
      for (int r = 0; r < 3; r++) begin
         q_data.sample[3*r]     = wc0_ff[r];
         q_data.sample[3*r + 1] = wc1_ff[r];
         q_data.sample[3*r + 2] = col[r];
      end
      q_data.row_last = b_last_ff;
   end

endmodule

// File: rtl/qdc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qdc_queue: window queue
// Short first-in first-out buffer of window beats between front and back.
// ----------------------------------------------------------------------------
module qdc_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  qdc_pkg::win_type           push_data,
   input  logic                       pop,
   output logic                       not_empty,
   output qdc_pkg::win_type           pop_data,
   output logic [qdc_pkg::QLVL_W-1:0] level
);

   localparam int QPTR_W = qdc_pkg::QPTR_W;
   localparam int QLVL_W = qdc_pkg::QLVL_W;
   localparam int DEPTH  = qdc_pkg::QUEUE_DEPTH;

   qdc_pkg::win_type  entry_ff [DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QLVL_W-1:0] level_ff;

   assign not_empty = (level_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign level     = level_ff;

   // Pointers and fill level.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == QPTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QPTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
         end
         if (push && !pop) begin
            level_ff <= level_ff + QLVL_W'(1);
         end else if (pop && !push) begin
            level_ff <= level_ff - QLVL_W'(1);
         end
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/qdc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qdc_back: multiply-accumulate and requantization pipeline
// Nine tap products, row sums, bias, fixed-point scaling with round half to
// even, output zero point and saturation, with a registered result beat.
// ----------------------------------------------------------------------------
module qdc_back (
   input  logic             clock,
   input  logic             reset,
   input  qdc_pkg::cfg_type cfg,
   input  logic             q_valid,
   input  qdc_pkg::win_type q_data,
   output logic             q_pop,
   qdc_rsp_if.source        rsp
);

   localparam int PROD_W     = qdc_pkg::PROD_W;
   localparam int ROW_W      = qdc_pkg::ROW_W;
   localparam int ACC_W      = qdc_pkg::ACC_W;
   localparam int MAG_W      = qdc_pkg::MAG_W;
   localparam int HALF_W     = qdc_pkg::HALF_W;
   localparam int FULL_W     = qdc_pkg::FULL_W;
   localparam int QRAW_W     = qdc_pkg::QRAW_W;
   localparam int Q_W        = qdc_pkg::Q_W;
   localparam int SCALE_FRAC = qdc_pkg::SCALE_FRAC;

   logic en;

   // Stage valids and row-end flags.
   logic p_valid_ff, s1_valid_ff, s2_valid_ff, a_valid_ff;
   logic m_valid_ff, r1_valid_ff, r2_valid_ff, o_valid_ff;
   logic p_last_ff, s1_last_ff, s2_last_ff, a_last_ff;
   logic m_last_ff, r1_last_ff, r2_last_ff, o_last_ff;

   logic signed [PROD_W-1:0] prod_ff [9];
   logic signed [PROD_W-1:0] prod_in [9];
   logic signed [7:0]        tap_w   [9];
   logic signed [ROW_W-1:0]  row_sum_ff [3];
   logic signed [ROW_W-1:0]  row_sum_in [3];
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic                     a_neg_ff, m_neg_ff, r1_neg_ff, r2_neg_ff;
   logic [MAG_W-1:0]         mag_ff, mag_in;
   logic [HALF_W-1:0]        hi_ff, lo_ff;
   logic [FULL_W-1:0]        full_ff;
   logic                     r1_big_ff;
   logic [QRAW_W-1:0]        q_raw;
   logic [SCALE_FRAC-1:0]    rem;
   logic                     round_up;
   logic [QRAW_W:0]          q_round;
   logic [Q_W-1:0]           q_in, q_ff;
   logic signed [12:0]       q_signed, r_val;
   logic [7:0]               out_in, out_value_ff;

   // The pipeline moves as a whole whenever the result register can take a beat.
   assign en    = !o_valid_ff || rsp.ready;
   assign q_pop = en && q_valid;

   // Tap products.
   always_comb begin
      for (int t = 0; t < 8; t++) begin
         tap_w[t] = $signed(cfg.weights_low[8*t +: 8]);
      end
      tap_w[8] = cfg.weight_last;
      for (int t = 0; t < 9; t++) begin
         prod_in[t] = tap_w[t] * $signed({1'b0, q_data.sample[t]});
      end
   end

   // Row sums, then the full accumulator with bias.
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         row_sum_in[r] = ROW_W'(prod_ff[3*r]) + ROW_W'(prod_ff[3*r + 1])
                       + ROW_W'(prod_ff[3*r + 2]);
      end
      acc_in = ACC_W'(cfg.bias) + ACC_W'(row_sum_ff[0]) + ACC_W'(row_sum_ff[1])
             + ACC_W'(row_sum_ff[2]);
      mag_in = acc_ff[ACC_W-1] ? MAG_W'(-acc_ff) : MAG_W'(acc_ff);
   end

   // Rounding of the scaled magnitude, half to even, clamped to the range
   // that can still reach the output after the zero point.
   always_comb begin
      q_raw    = full_ff[FULL_W-1:SCALE_FRAC];
      rem      = full_ff[SCALE_FRAC-1:0];
      round_up = (rem > (SCALE_FRAC'(1) << (SCALE_FRAC - 1)))
              || ((rem == (SCALE_FRAC'(1) << (SCALE_FRAC - 1))) && q_raw[0]);
      q_round  = {1'b0, q_raw} + {{QRAW_W{1'b0}}, round_up};
      if (r1_big_ff || (q_round > (QRAW_W + 1)'(qdc_pkg::Q_MAX))) begin
         q_in = Q_W'(qdc_pkg::Q_MAX);
      end else begin
         q_in = q_round[Q_W-1:0];
      end
   end

   // Sign, output zero point and saturation to a byte.
   always_comb begin
      q_signed = r2_neg_ff ? -$signed({2'b00, q_ff}) : $signed({2'b00, q_ff});
      r_val    = q_signed + $signed({5'b00000, cfg.out_zero});
      if (r_val < 13'sd0) begin
         out_in = 8'd0;
      end else if (r_val > 13'sd255) begin
         out_in = 8'd255;
      end else begin
         out_in = r_val[7:0];
      end
   end

   // Stage valids.
   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff  <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         a_valid_ff  <= 1'b0;
         m_valid_ff  <= 1'b0;
         r1_valid_ff <= 1'b0;
         r2_valid_ff <= 1'b0;
         o_valid_ff  <= 1'b0;
      end else if (en) begin
         p_valid_ff  <= q_valid;
         s1_valid_ff <= p_valid_ff;
         s2_valid_ff <= s1_valid_ff;
         a_valid_ff  <= s2_valid_ff;
         m_valid_ff  <= a_valid_ff;
         r1_valid_ff <= m_valid_ff;
         r2_valid_ff <= r1_valid_ff;
         o_valid_ff  <= r2_valid_ff;
      end
   end

   // Stage payloads.
   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff      <= prod_in;
         p_last_ff    <= q_data.row_last;
         row_sum_ff   <= row_sum_in;
         s1_last_ff   <= p_last_ff;
         acc_ff       <= acc_in;
         s2_last_ff   <= s1_last_ff;
         a_neg_ff     <= acc_ff[ACC_W-1];
         mag_ff       <= mag_in;
         a_last_ff    <= s2_last_ff;
         hi_ff        <= mag_ff * cfg.scale_mult[31:16];
         lo_ff        <= mag_ff * cfg.scale_mult[15:0];
         m_neg_ff     <= a_neg_ff;
         m_last_ff    <= a_last_ff;
         r1_big_ff    <= hi_ff[HALF_W-1];
         full_ff      <= {hi_ff[FULL_W-17:0], 16'h0000} + {16'h0000, lo_ff};
         r1_neg_ff    <= m_neg_ff;
         r1_last_ff   <= m_last_ff;
         q_ff         <= q_in;
         r2_neg_ff    <= r1_neg_ff;
         r2_last_ff   <= r1_last_ff;
         out_value_ff <= out_in;
         o_last_ff    <= r2_last_ff;
      end
   end

   assign rsp.valid     = o_valid_ff;
   assign rsp.out_value = out_value_ff;
   assign rsp.row_last  = o_last_ff;

endmodule

// File: tb/sv/qdc_test_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qdc_test_pkg: result scoreboard for the 3x3 depthwise convolution test
// Mirrors the configuration, the two line stores, the sliding window and the
// requantization of the block. Each accepted pixel beat may queue one
// expected result. Result beats are compared in order against that queue.
// ----------------------------------------------------------------------------
package qdc_test_pkg;
   import qdc_pkg::*;

   localparam int MAX_REPORTS = 30;

   typedef struct packed {
      logic [7:0] out_value;
      logic       row_last;
   } conv_result_type;

   class qdc_conv_scoreboard;
      cfg_type         cfg;
      logic [7:0]      row_above [MAX_PADDED_WIDTH];
      logic [7:0]      row_two_above [MAX_PADDED_WIDTH];
      logic [7:0]      win_older [3];
      logic [7:0]      win_newer [3];
      int unsigned     column_pos;
      int unsigned     row_pos;
      conv_result_type expected_results [$];
      int              pixels_noted;
      int              results_checked;
      int              row_ends;
      int              rail_results;
      int              mismatches;

      function new();
         cfg              = '0;
         cfg.scale_mult   = SCALE_RESET;
         cfg.padded_width = PW_W'(MAX_PADDED_WIDTH);
         foreach (row_above[i]) begin
            row_above[i]     = '0;
            row_two_above[i] = '0;
         end
         foreach (win_older[i]) begin
            win_older[i] = '0;
            win_newer[i] = '0;
         end
         column_pos      = 0;
         row_pos         = 0;
         pixels_noted    = 0;
         results_checked = 0;
         row_ends        = 0;
         rail_results    = 0;
         mismatches      = 0;
      endfunction

      function int pending();
         return expected_results.size();
      endfunction

      // Register writes keep only the bits that each register holds.
      function void write_register(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         case (index)
            CSR_WEIGHTS_LOW:  cfg.weights_low  = data;
            CSR_WEIGHT_LAST:  cfg.weight_last  = data[7:0];
            CSR_BIAS:         cfg.bias         = data[31:0];
            CSR_SCALE_MULT:   cfg.scale_mult   = data[31:0];
            CSR_IN_ZERO:      cfg.in_zero      = data[7:0];
            CSR_OUT_ZERO:     cfg.out_zero     = data[7:0];
            CSR_PADDED_WIDTH: cfg.padded_width = data[PW_W-1:0];
            default: ;
         endcase
      endfunction

      // Signed kernel weight of tap 3*row + column.
      function int kernel_tap(int tap);
         logic signed [7:0] w;
         if (tap < 8) begin
            w = cfg.weights_low[8*tap +: 8];
         end else begin
            w = cfg.weight_last;
         end
         return int'(w);
      endfunction

      // Scale the accumulator by the fixed-point multiplier, round half to even,
      // add the output zero point and clip to a byte.
      function logic [7:0] scale_to_byte(longint acc);
         longint unsigned mag, hi, lo, prod, rem, q, half;
         longint          value;
         half = 64'd1 << (SCALE_FRAC - 1);
         mag  = (acc < 0) ? -acc : acc;
         hi   = mag * {48'd0, cfg.scale_mult[31:16]};
         lo   = mag * {48'd0, cfg.scale_mult[15:0]};
         if (hi >= 64'h0000_8000_0000_0000) begin
            q = Q_MAX;
         end else begin
            prod = (hi << 16) + lo;
            rem  = prod & ((64'd1 << SCALE_FRAC) - 64'd1);
            q    = prod >> SCALE_FRAC;
            if (rem > half || (rem == half && q[0])) begin
               q++;
            end
            if (q > Q_MAX) begin
               q = Q_MAX;
            end
         end
         value = (acc < 0) ? -longint'(q) : longint'(q);
         value = value + int'(cfg.out_zero);
         if (value < 0) begin
            value = 0;
         end
         if (value > 255) begin
            value = 255;
         end
         if (value == 0 || value == 255) begin
            rail_results++;
         end
         return 8'(value);
      endfunction

      // Advance the line stores and window by one accepted pixel beat and queue
      // the result once the window lies inside the frame.
      function void note_pixel(logic [7:0] pixel, logic is_pad, logic frame_start);
         int unsigned width, col;
         logic [7:0]  column [3];
         logic        last;
         longint      acc;
         width = cfg.padded_width;
         if (width < 3) begin
            width = 3;
         end
         if (width > MAX_PADDED_WIDTH) begin
            width = MAX_PADDED_WIDTH;
         end
         pixels_noted++;
         if (frame_start) begin
            column_pos = 0;
            row_pos    = 0;
         end
         // A column left over from a wider setting ends the row.
         col  = (column_pos >= width) ? width - 1 : column_pos;
         last = (col == width - 1);

         column[0] = row_two_above[col];
         column[1] = row_above[col];
         column[2] = is_pad ? cfg.in_zero : pixel;
         row_two_above[col] = column[1];
         row_above[col]     = column[2];

         if (row_pos >= 2 && col >= 2) begin
            acc = $signed(cfg.bias);
            for (int r = 0; r < 3; r++) begin
               acc += longint'(kernel_tap(3*r) * int'(win_older[r])
                             + kernel_tap(3*r + 1) * int'(win_newer[r])
                             + kernel_tap(3*r + 2) * int'(column[r]));
            end
            expected_results.push_back('{out_value: scale_to_byte(acc), row_last: last});
            if (last) begin
               row_ends++;
            end
         end

         win_older = win_newer;
         win_newer = column;
         if (last) begin
            column_pos = 0;
            if (row_pos < 2) begin
               row_pos++;
            end
         end else begin
            column_pos = col + 1;
         end
      endfunction

      // Compare one result beat with the oldest expectation.
      function void check_result(logic [7:0] out_value, logic row_last);
         conv_result_type want;
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("%0t: result beat with none expected: expected nothing, actual %0d/%0b",
                        $time, out_value, row_last);
            end
            return;
         end
         want = expected_results.pop_front();
         results_checked++;
         if (out_value !== want.out_value) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("%0t: out_value mismatch: expected %0d, actual %0d",
                        $time, want.out_value, out_value);
            end
         end
         if (row_last !== want.row_last) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("%0t: row_last mismatch: expected %0b, actual %0b",
                        $time, want.row_last, row_last);
            end
         end
      endfunction
   endclass

endpackage

// File: tb/sv/quantized_depthwise_conv3x3_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quantized_depthwise_conv3x3_test: stream test of the 3x3 depthwise conv
// Writes the registers between phases, streams padded frames, truncated
// frames and loose pixel beats with bursty input and a stalling result side,
// and checks every result beat against the scoreboard's prediction.
// ----------------------------------------------------------------------------
module quantized_depthwise_conv3x3_test;
   import qdc_pkg::*;
   import qdc_test_pkg::*;

   localparam int RANDOM_ITEMS  = 1150;
   localparam int SETTLE_CYCLES = 40;
   localparam int IDLE_LIMIT    = 2000;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;

   typedef enum int {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC,
      STALL_BLOCKS
   } stall_mode_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   qdc_req_if req_ch ();
   qdc_rsp_if rsp_ch ();

   qdc_conv_scoreboard sb;
   int             items_sent;
   int             burst_left;
   int             phase_count;
   int             idle_cycles;
   stall_mode_type stall_mode = STALL_NONE;
   int             mode_left  = 0;
   int             hold_left  = 0;
   logic           hold_on    = 1'b0;

   quantized_depthwise_conv3x3 DUT (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Result side ready: the stall style is redrawn whenever its run ends.
   always @(negedge clock) begin
      if (mode_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 4));
         mode_left  = $urandom_range(40, 200);
      end
      mode_left--;
      case (stall_mode)
         STALL_NONE:     rsp_ch.ready = 1'b1;
         STALL_LIGHT:    rsp_ch.ready = ($urandom_range(0, 3) != 0);
         STALL_HEAVY:    rsp_ch.ready = ($urandom_range(0, 9) < 3);
         STALL_PERIODIC: rsp_ch.ready = (mode_left % 5 != 0);
         default: begin
            if (hold_left == 0) begin
               hold_on   = !hold_on;
               hold_left = hold_on ? $urandom_range(3, 20) : $urandom_range(10, 30);
            end
            hold_left--;
            rsp_ch.ready = hold_on;
         end
      endcase
   end

   // Result checking and the watchdog on cycles without any beat.
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            sb.check_result(rsp_ch.out_value, rsp_ch.row_last);
         end
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles, %0d results outstanding",
                     $time, IDLE_LIMIT, sb.pending());
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // Random upper bits above the bits that a register keeps.
   function automatic logic [63:0] with_noise(input logic [63:0] value, input int bits);
      logic [63:0] mask;
      mask = (64'd1 << bits) - 64'd1;
      return ({$urandom, $urandom} & ~mask) | (value & mask);
   endfunction

   task automatic write_csr(input logic [CSR_IDX_W-1:0] index, input logic [63:0] data);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = index;
      csr_wdata = data;
      @(negedge clock);
      csr_we = 1'b0;
      sb.write_register(index, data);
   endtask

   // Offer one pixel beat; bursts of random length are separated by random gaps, sometimes none.
   task automatic send_beat(input logic [7:0] pixel, input logic is_pad, input logic frame_start);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 48);
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            @(negedge clock);
            req_ch.valid = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_ch.valid       = 1'b1;
      req_ch.pixel       = pixel;
      req_ch.is_pad      = is_pad;
      req_ch.frame_start = frame_start;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_pixel(pixel, is_pad, frame_start);
      items_sent++;
   endtask

   // Stop offering beats and wait until every expected result has arrived.
   task automatic drain_results(input int settle);
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // Padded frame in raster order, pad beats on the border, random pixels.
   task automatic send_frame(input int width, input int rows, input bit with_start,
                             input int count, input int pause_at);
      int r, c;
      for (int i = 0; i < count; i++) begin
         if (i == pause_at) begin
            drain_results(0);
         end
         r = i / width;
         c = i % width;
         send_beat(8'($urandom_range(0, 255)),
                   (r == 0 || r == rows - 1 || c == 0 || c == width - 1),
                   with_start && i == 0);
      end
   endtask

   initial begin
      int          random_start, width_setting, width, rows, kind, pause_at;
      logic [63:0] weights;
      logic [31:0] scale, bias_val;

      sb                 = new();
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.pixel       = '0;
      req_ch.is_pad      = 1'b0;
      req_ch.frame_start = 1'b0;
      rsp_ch.ready       = 1'b0;
      csr_we             = 1'b0;
      csr_index          = '0;
      csr_wdata          = '0;
      items_sent         = 0;
      burst_left         = 0;
      phase_count        = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Largest positive weights with a negative last tap on a minimal frame.
      write_csr(CSR_WEIGHTS_LOW, 64'h7F7F_7F7F_7F7F_7F7F);
      write_csr(CSR_WEIGHT_LAST, with_noise(64'h80, 8));
      write_csr(CSR_BIAS, with_noise(64'h0, 32));
      write_csr(CSR_SCALE_MULT, with_noise(SCALE_RESET, 32));
      write_csr(CSR_IN_ZERO, with_noise(64'hFF, 8));
      write_csr(CSR_OUT_ZERO, with_noise(64'h0, 8));
      write_csr(CSR_PADDED_WIDTH, with_noise(64'd3, PW_W));
      write_csr(CSR_UNUSED, {$urandom, $urandom});
      send_frame(3, 3, 1'b1, 9, -1);
      drain_results(SETTLE_CYCLES);

      // Most negative low weights and bias, largest scale, no frame start.
      write_csr(CSR_WEIGHTS_LOW, 64'h8080_8080_8080_8080);
      write_csr(CSR_WEIGHT_LAST, with_noise(64'h7F, 8));
      write_csr(CSR_BIAS, with_noise(64'h8000_0000, 32));
      write_csr(CSR_SCALE_MULT, with_noise(64'hFFFF_FFFF, 32));
      write_csr(CSR_IN_ZERO, with_noise(64'h0, 8));
      write_csr(CSR_OUT_ZERO, with_noise(64'hFF, 8));
      repeat (3) send_beat(8'hFF, 1'b0, 1'b0);
      drain_results(SETTLE_CYCLES);
      write_csr(CSR_BIAS, with_noise(64'h7FFF_FFFF, 32));
      repeat (3) send_beat(8'h00, 1'b1, 1'b0);
      drain_results(SETTLE_CYCLES);

      // Exact halves from a scale of one half on the last tap, width below minimum.
      write_csr(CSR_WEIGHTS_LOW, 64'h0);
      write_csr(CSR_WEIGHT_LAST, with_noise(64'h01, 8));
      write_csr(CSR_BIAS, with_noise(64'h0, 32));
      write_csr(CSR_SCALE_MULT, with_noise(64'h0080_0000, 32));
      write_csr(CSR_OUT_ZERO, with_noise(64'd128, 8));
      write_csr(CSR_PADDED_WIDTH, with_noise(64'd1, PW_W));
      repeat (2) send_beat(8'd0, 1'b0, 1'b0);
      send_beat(8'd5, 1'b0, 1'b0);
      repeat (2) send_beat(8'd0, 1'b0, 1'b0);
      send_beat(8'd7, 1'b0, 1'b0);
      drain_results(SETTLE_CYCLES);

      // Width lowered while the column count sits past the new last column.
      write_csr(CSR_PADDED_WIDTH, with_noise(64'd6, PW_W));
      repeat (4) send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      drain_results(SETTLE_CYCLES);
      write_csr(CSR_PADDED_WIDTH, with_noise(64'd3, PW_W));
      repeat (2) send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      drain_results(SETTLE_CYCLES);

      // Random phases: new settings, then a frame, a broken frame or loose beats.
      random_start = items_sent;
      while (items_sent - random_start < RANDOM_ITEMS) begin
         if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 5))
               0:       weights = 64'h7F7F_7F7F_7F7F_7F7F;
               1:       weights = 64'h8080_8080_8080_8080;
               2:       weights = 64'h807F_807F_807F_807F;
               default: weights = {$urandom, $urandom};
            endcase
            write_csr(CSR_WEIGHTS_LOW, weights);
         end
         if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 4))
               0:       write_csr(CSR_WEIGHT_LAST, with_noise(64'h7F, 8));
               1:       write_csr(CSR_WEIGHT_LAST, with_noise(64'h80, 8));
               default: write_csr(CSR_WEIGHT_LAST, {$urandom, $urandom});
            endcase
         end
         if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 9))
               0:       bias_val = 32'h7FFF_FFFF;
               1:       bias_val = 32'h8000_0000;
               default: bias_val = $urandom_range(0, 40000) - 20000;
            endcase
            write_csr(CSR_BIAS, with_noise(bias_val, 32));
         end
         if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 9))
               0:       scale = 32'h0;
               1:       scale = 32'hFFFF_FFFF;
               2:       scale = 32'h0080_0000;
               3:       scale = 32'h0100_0000;
               4:       scale = 32'h0040_0000;
               default: scale = $urandom_range(32'h2000, 32'h2_0000);
            endcase
            write_csr(CSR_SCALE_MULT, with_noise(scale, 32));
         end
         if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 4))
               0:       write_csr(CSR_IN_ZERO, with_noise(64'h00, 8));
               1:       write_csr(CSR_IN_ZERO, with_noise(64'hFF, 8));
               default: write_csr(CSR_IN_ZERO, {$urandom, $urandom});
            endcase
         end
         if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 4))
               0:       write_csr(CSR_OUT_ZERO, with_noise(64'h00, 8));
               1:       write_csr(CSR_OUT_ZERO, with_noise(64'hFF, 8));
               default: write_csr(CSR_OUT_ZERO, {$urandom, $urandom});
            endcase
         end

         if (phase_count == 2) begin
            // One full-width row, then a narrower width reached mid-row.
            width_setting = $urandom_range(0, 1) ? MAX_PADDED_WIDTH : $urandom_range(257, 511);
            write_csr(CSR_PADDED_WIDTH, with_noise(width_setting, PW_W));
            repeat (MAX_PADDED_WIDTH + $urandom_range(20, 60)) begin
               send_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0);
            end
            drain_results(SETTLE_CYCLES);
            write_csr(CSR_PADDED_WIDTH, with_noise($urandom_range(3, 10), PW_W));
            repeat (12) send_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0);
         end else begin
            case ($urandom_range(0, 19))
               0, 1:    width_setting = $urandom_range(0, 2);
               2, 3:    width_setting = $urandom_range(11, 40);
               default: width_setting = $urandom_range(3, 10);
            endcase
            write_csr(CSR_PADDED_WIDTH, with_noise(width_setting, PW_W));
            width = (width_setting < 3) ? 3 : width_setting;
            rows  = $urandom_range(3, 6);
            kind  = (phase_count == 4) ? 0 : $urandom_range(0, 99);
            if (kind < 70) begin
               // Well-formed frame; now and then the sender holds mid-frame
               // until every result so far has come out.
               pause_at = (phase_count == 4 || $urandom_range(0, 9) == 0)
                          ? $urandom_range(1, width * rows - 1) : -1;
               send_frame(width, rows, 1'b1, width * rows, pause_at);
            end else if (kind < 88) begin
               send_frame(width, rows, 1'($urandom_range(0, 1)),
                          $urandom_range(1, width * rows), -1);
            end else begin
               repeat ($urandom_range(5, 40)) begin
                  send_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                            $urandom_range(0, 15) == 0);
               end
            end
         end
         drain_results(SETTLE_CYCLES);
         phase_count++;
      end

      drain_results(SETTLE_CYCLES);
      $display("Run covered %0d pixel beats over %0d random settings phases, %0d result beats.",
               items_sent, phase_count, sb.results_checked);
      $display("Row ends: %0d, results on the 0 or 255 rails: %0d, mismatches: %0d.",
               sb.row_ends, sb.rail_results, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/qdc_pkg.sv
rtl/qdc_req_if.sv
rtl/qdc_rsp_if.sv
rtl/qdc_front.sv
rtl/qdc_queue.sv
rtl/qdc_back.sv
rtl/quantized_depthwise_conv3x3.sv
tb/sv/qdc_test_pkg.sv
tb/sv/quantized_depthwise_conv3x3_test.sv
